### rtl/frame_postfilter_crossfade_assert.svh
// Assertion macros shared by the post-filter modules.
`ifndef FRAME_POSTFILTER_CROSSFADE_ASSERT_SVH
`define FRAME_POSTFILTER_CROSSFADE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion %m failed");

// The consequent must hold in the cycle after the antecedent.
`define FPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion %m failed");

`endif

### rtl/fpc_pkg.sv
package fpc_pkg;

   // Frame geometry. The overlap length is a power of two.
   localparam int FRAME_LEN    = 4096;
   localparam int OVERLAP_LOG2 = 5;
   localparam int OVERLAP      = 1 << OVERLAP_LOG2;
   localparam int STORE_BASE   = FRAME_LEN - OVERLAP;
   localparam int POS_W        = $clog2(FRAME_LEN);

   // Data widths.
   localparam int IN_W     = 32;
   localparam int X_W      = 24;
   localparam int HIST_W   = 24;
   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = OVERLAP_LOG2;
   localparam int WT_W     = OVERLAP_LOG2 + 1;

   // Prescale shifts: divide by 1024, or by 2048 after tripling in boost mode.
   localparam int SHIFT_NORMAL = 10;
   localparam int SHIFT_BOOST  = 11;

   // Smoothing recursion constants.
   localparam int FILTER_GAIN  = 27;
   localparam int FILTER_SHIFT = 5;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Saturation limits of the output sample.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // One classified item as it travels from front to back.
   typedef struct packed {
      logic [X_W-1:0]   x;
      logic             clear;
      logic             fade;
      logic             store;
      logic             frame_end;
      logic [IDX_W-1:0] idx;
   } entry_type;

endpackage

### rtl/fpc_ram.sv
module fpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fpc_front.sv
`include "frame_postfilter_crossfade_assert.svh"

module fpc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           boost_mode,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fpc_pkg::IN_W-1:0]       req_coefficient,
   input  logic                           req_stream_start,
   output logic                           push_valid,
   input  logic                           push_ready,
   output fpc_pkg::entry_type             push_data
);

   localparam int IN_W  = fpc_pkg::IN_W;
   localparam int X_W   = fpc_pkg::X_W;
   localparam int POS_W = fpc_pkg::POS_W;
   localparam int IDX_W = fpc_pkg::IDX_W;
   localparam int T_W   = IN_W + 3;
   localparam logic [T_W-1:0] BIAS_NORMAL = T_W'((1 << fpc_pkg::SHIFT_NORMAL) - 1);
   localparam logic [T_W-1:0] BIAS_BOOST  = T_W'((1 << fpc_pkg::SHIFT_BOOST) - 1);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             seen_ff;
   logic             seen_in;
   logic [POS_W-1:0] pos_cur;
   logic             seen_cur;
   logic             accept;
   logic             last;
   logic [T_W-1:0]   raw_ext;
   logic [T_W-1:0]   raw_double;
   logic [T_W-1:0]   bias;
   logic [T_W-1:0]   scaled;
   fpc_pkg::entry_type entry;

   // A transfer goes straight into the queue.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // A stream start restarts the frame before this item.
   assign pos_cur  = req_stream_start ? '0 : pos_ff;
   assign seen_cur = req_stream_start ? 1'b0 : seen_ff;
   assign last     = (pos_cur == POS_W'(fpc_pkg::FRAME_LEN - 1));

   // Prescale with truncation toward zero: bias negative values before the shift.
   assign raw_ext    = {{(T_W-IN_W){req_coefficient[IN_W-1]}}, req_coefficient};
   assign raw_double = boost_mode ? (raw_ext << 1) : '0;
   assign bias       = req_coefficient[IN_W-1] ?
                       (boost_mode ? BIAS_BOOST : BIAS_NORMAL) : '0;
   assign scaled     = raw_ext + raw_double + bias;

   // Classify the item by its place in the frame.
   always_comb begin
      entry.x         = boost_mode ? scaled[fpc_pkg::SHIFT_BOOST +: X_W]
                                   : scaled[fpc_pkg::SHIFT_NORMAL +: X_W];
      entry.clear     = req_stream_start;
      entry.fade      = seen_cur && (pos_cur < POS_W'(fpc_pkg::OVERLAP));
      entry.store     = (pos_cur >= POS_W'(fpc_pkg::STORE_BASE));
      entry.frame_end = (pos_cur == POS_W'(fpc_pkg::STORE_BASE - 1));
      entry.idx       = entry.store ? IDX_W'(pos_cur - POS_W'(fpc_pkg::STORE_BASE))
                                    : pos_cur[IDX_W-1:0];
   end

   assign push_data = entry;

   // Frame position and frame-seen flag advance on each transfer.
   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (accept) begin
         pos_in  = last ? '0 : pos_cur + POS_W'(1);
         seen_in = last || seen_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
      end
   end

   // The item after the last emitted one starts the stored tail.
   `FPC_ASSERT_NEXT(a_tail_follows_end, clock, reset, accept && entry.frame_end, pos_ff == POS_W'(fpc_pkg::STORE_BASE))

endmodule

### rtl/fpc_queue.sv
`include "frame_postfilter_crossfade_assert.svh"

module fpc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  fpc_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output fpc_pkg::entry_type pop_data
);

   localparam int DEPTH = fpc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   fpc_pkg::entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A lone push grows the occupancy by exactly one.
   `FPC_ASSERT_NEXT(a_push_counts, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

### rtl/fpc_back.sv
`include "frame_postfilter_crossfade_assert.svh"

module fpc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  fpc_pkg::entry_type               pop_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fpc_pkg::SAMPLE_W-1:0]     rsp_pcm_sample,
   output logic                             rsp_frame_end
);

   localparam int X_W      = fpc_pkg::X_W;
   localparam int HIST_W   = fpc_pkg::HIST_W;
   localparam int SAMPLE_W = fpc_pkg::SAMPLE_W;
   localparam int IDX_W    = fpc_pkg::IDX_W;
   localparam int WT_W     = fpc_pkg::WT_W;
   localparam int SUM_W    = 30;
   localparam int MIX_W    = HIST_W + WT_W + 1;
   localparam int Q_W      = MIX_W - fpc_pkg::OVERLAP_LOG2;
   localparam logic [SUM_W-1:0] SUM_BIAS = SUM_W'((1 << fpc_pkg::FILTER_SHIFT) - 1);
   localparam logic [MIX_W-1:0] MIX_BIAS = MIX_W'(fpc_pkg::OVERLAP - 1);

   typedef enum logic [3:0] {
      ST_SUM  = 4'b0001,
      ST_FILT = 4'b0010,
      ST_MIX  = 4'b0100,
      ST_OUT  = 4'b1000
   } back_state_type;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [HIST_W-1:0]     h1_ff;
   logic [HIST_W-1:0]     h2_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [HIST_W-1:0]     y_ff;
   logic [MIX_W-1:0]      mix_ff;
   logic                  fade_ff;
   logic                  store_ff;
   logic                  frame_end_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_pcm_sample_ff;
   logic                  rsp_frame_end_ff;
   logic                  take;
   logic [HIST_W-1:0]     h1_use;
   logic [HIST_W-1:0]     h2_use;
   logic [SUM_W-1:0]      sum_in;
   logic [SUM_W-1:0]      sum_biased;
   logic [HIST_W-1:0]     y_new;
   logic [WT_W-1:0]       tail_weight;
   logic [MIX_W-1:0]      prod_new;
   logic [MIX_W-1:0]      prod_tail;
   logic [MIX_W-1:0]      mix_biased;
   logic [Q_W-1:0]        faded;
   logic [Q_W-1:0]        pre_sat;
   logic [Q_W-SAMPLE_W:0] upper;
   logic [SAMPLE_W-1:0]   sat;
   logic [SAMPLE_W-1:0]   tail_data;
   logic                  out_load;
   logic                  tail_write;

   // One item is in work at a time; the next is taken in the sum step.
   assign pop_ready = (state_ff == ST_SUM);
   assign take      = pop_valid && pop_ready;

   // Sum step: 27*x + 4*y1 + y2, with histories cleared at a stream start.
   assign h1_use = pop_data.clear ? '0 : h1_ff;
   assign h2_use = pop_data.clear ? '0 : h2_ff;
   assign sum_in = SUM_W'(fpc_pkg::FILTER_GAIN) *
                   {{(SUM_W-X_W){pop_data.x[X_W-1]}}, pop_data.x}
                 + ({{(SUM_W-HIST_W){h1_use[HIST_W-1]}}, h1_use} << 2)
                 + {{(SUM_W-HIST_W){h2_use[HIST_W-1]}}, h2_use};

   // Filter step: divide by 32 truncating toward zero.
   assign sum_biased = sum_ff + (sum_ff[SUM_W-1] ? SUM_BIAS : '0);
   assign y_new      = sum_biased[fpc_pkg::FILTER_SHIFT +: HIST_W];

   // Mix step: weighted blend of the new value and the stored tail.
   assign tail_weight = WT_W'(fpc_pkg::OVERLAP) - {1'b0, idx_ff};
   assign prod_new    = MIX_W'(idx_ff) * {{(MIX_W-HIST_W){y_ff[HIST_W-1]}}, y_ff};
   assign prod_tail   = MIX_W'(tail_weight) *
                        {{(MIX_W-SAMPLE_W){tail_data[SAMPLE_W-1]}}, tail_data};

   // Output step: scale the blend down, pick the source and saturate.
   assign mix_biased = mix_ff + (mix_ff[MIX_W-1] ? MIX_BIAS : '0);
   assign faded      = mix_biased[fpc_pkg::OVERLAP_LOG2 +: Q_W];
   assign pre_sat    = fade_ff ? faded : {{(Q_W-HIST_W){y_ff[HIST_W-1]}}, y_ff};
   assign upper      = pre_sat[Q_W-1:SAMPLE_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat = pre_sat[SAMPLE_W-1:0];
      end else if (pre_sat[Q_W-1]) begin
         sat = fpc_pkg::SAMPLE_MIN;
      end else begin
         sat = fpc_pkg::SAMPLE_MAX;
      end
   end

   // Tail items go to the store; the rest wait for room in the output register.
   assign tail_write = (state_ff == ST_OUT) && store_ff;
   assign out_load   = (state_ff == ST_OUT) && !store_ff && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SUM: begin
            if (take) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (tail_write || out_load) begin
               state_in = ST_SUM;
            end
         end
         default: begin
            state_in = ST_SUM;
         end
      endcase
   end

   // Output valid is set on a load and cleared when the sample is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and filter history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SUM;
         rsp_valid_ff <= 1'b0;
         h1_ff        <= '0;
         h2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take && pop_data.clear) begin
            h1_ff <= '0;
            h2_ff <= '0;
         end else if (state_ff == ST_FILT) begin
            h1_ff <= y_new;
            h2_ff <= h1_ff;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (take) begin
         sum_ff       <= sum_in;
         fade_ff      <= pop_data.fade;
         store_ff     <= pop_data.store;
         frame_end_ff <= pop_data.frame_end;
         idx_ff       <= pop_data.idx;
      end
      if (state_ff == ST_FILT) begin
         y_ff <= y_new;
      end
      if (state_ff == ST_MIX) begin
         mix_ff <= prod_new + prod_tail;
      end
      if (out_load) begin
         rsp_pcm_sample_ff <= sat;
         rsp_frame_end_ff  <= frame_end_ff;
      end
   end

   // Tail store of the previous frame, read when the item is taken.
   fpc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (fpc_pkg::OVERLAP)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_write),
      .wr_addr (idx_ff),
      .wr_data (sat),
      .rd_en   (take),
      .rd_addr (pop_data.idx),
      .rd_data (tail_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_pcm_sample_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

   // Writing the tail never stalls the sequencer.
   `FPC_ASSERT_NEXT(a_store_no_stall, clock, reset, tail_write, state_ff == ST_SUM)
   // A new sample appears only from the output step of a non-tail item.
   `FPC_ASSERT_SAME(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT && !$past(store_ff))
   // The fade and store regions of a frame never overlap.
   `FPC_ASSERT_SAME(a_fade_store_apart, clock, reset, state_ff != ST_SUM, !(fade_ff && store_ff))

endmodule

### rtl/frame_postfilter_crossfade.sv
// Frame post-filter with crossfade.
// Input channel req_*: one signed 32-bit transform value per transfer, with
// req_stream_start marking the first item of a new stream. Items form frames
// of 4096; the last 32 of each frame are kept as a tail and produce no sample.
// Result channel rsp_*: one saturated 16-bit sample per non-tail item, with
// rsp_frame_end set on the last sample of a frame. The first 32 samples of
// every frame after the first are blended with the previous frame's tail.
// csr_wr_en / csr_wr_data write the boost_mode bit; write it only while idle.
// An input transfer is written into the queue; the back end takes it in its
// sum step, then runs the filter and mix steps and loads the sample into the
// output register in its output step, working on one item at a time.
// A two-entry queue between front and back keeps accepting input while the
// back end works, and the output register holds a finished sample while the
// next item is processed; when rsp_ready stays low the back end waits in its
// output step, the queue fills and req_ready drops.
// Reset (synchronous, active high) clears frame position, history, queue
// and boost_mode; it needs no clearing pass.
module frame_postfilter_crossfade (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fpc_pkg::IN_W-1:0]     req_coefficient,
   input  logic                         req_stream_start,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fpc_pkg::SAMPLE_W-1:0] rsp_pcm_sample,
   output logic                         rsp_frame_end
);

   logic               boost_mode_ff;
   logic               boost_mode_in;
   logic               push_valid;
   logic               push_ready;
   fpc_pkg::entry_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   fpc_pkg::entry_type pop_data;

   // Configuration register.
   assign boost_mode_in = csr_wr_en ? csr_wr_data : boost_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         boost_mode_ff <= 1'b0;
      end else begin
         boost_mode_ff <= boost_mode_in;
      end
   end

   // Front end: prescale and classify each transfer.
   fpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .boost_mode       (boost_mode_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .req_stream_start (req_stream_start),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // Queue between front and back.
   fpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: recursion, crossfade, saturation and output register.
   fpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pcm_sample (rsp_pcm_sample),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

### tb/crossfade_sample_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the post-filter. For every
// input transfer it runs its own copy of the prescale, smoothing and crossfade
// arithmetic, and queues the sample that a non-tail item should produce.
// Every result transfer is compared with the oldest queued sample.
module crossfade_sample_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [fpc_pkg::IN_W-1:0]     req_coefficient,
   input  logic                         req_stream_start,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [fpc_pkg::SAMPLE_W-1:0] rsp_pcm_sample,
   input  logic                         rsp_frame_end,
   output int                           mismatch_count,
   output int                           pending_count
);
   import fpc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] pcm_sample;
      logic                frame_end;
   } sample_type;

   sample_type                 expected_samples[$];
   logic                       boost_mode;
   longint                     history_one;
   longint                     history_two;
   int                         frame_position;
   logic                       frame_seen;
   logic signed [SAMPLE_W-1:0] tail_samples[OVERLAP];
   int                         mismatches;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      mismatches     = 0;
   end

   // Clamps a value to the signed 16-bit sample range.
   function automatic longint clamp_sample(input longint value);
      if (value > longint'($signed(SAMPLE_MAX))) begin
         return longint'($signed(SAMPLE_MAX));
      end
      if (value < longint'($signed(SAMPLE_MIN))) begin
         return longint'($signed(SAMPLE_MIN));
      end
      return value;
   endfunction

   // Runs one coefficient through the filter state. Tail positions only
   // update the stored tail; every other position queues one sample.
   task automatic filter_coefficient(input logic [IN_W-1:0] coefficient,
                                     input logic stream_start);
      longint     x;
      longint     y;
      longint     s;
      int         pos;
      sample_type sample;
      if (stream_start) begin
         history_one    = 0;
         history_two    = 0;
         frame_position = 0;
         frame_seen     = 1'b0;
      end

      // Prescale, with every division truncating toward zero.
      x = longint'($signed(coefficient));
      if (boost_mode) begin
         x = ((3 * x) / 2) / (1 << SHIFT_NORMAL);
      end else begin
         x = x / (1 << SHIFT_NORMAL);
      end

      // Smoothing recursion on the unsaturated history.
      y = (FILTER_GAIN * x + 4 * history_one + history_two) / (1 << FILTER_SHIFT);
      history_two = history_one;
      history_one = y;

      pos = (frame_position >= FRAME_LEN) ? 0 : frame_position;

      // The head of every frame after the first blends in the previous tail.
      s = y;
      if (pos < OVERLAP && frame_seen) begin
         s = (longint'(pos) * y + longint'(OVERLAP - pos) * longint'(tail_samples[pos]))
             / OVERLAP;
      end
      s = clamp_sample(s);

      if (pos >= STORE_BASE) begin
         tail_samples[pos - STORE_BASE] = s[SAMPLE_W-1:0];
      end else begin
         sample.pcm_sample = s[SAMPLE_W-1:0];
         sample.frame_end  = (pos == STORE_BASE - 1);
         expected_samples.push_back(sample);
      end

      if (pos == FRAME_LEN - 1) begin
         frame_position = 0;
         frame_seen     = 1'b1;
      end else begin
         frame_position = pos + 1;
      end
   endtask

   // Results are checked before the input of the same edge is predicted,
   // since a sample can never leave in the cycle its input arrives.
   always @(posedge clock) begin
      sample_type wanted;
      if (reset) begin
         boost_mode     = 1'b0;
         history_one    = 0;
         history_two    = 0;
         frame_position = 0;
         frame_seen     = 1'b0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: unexpected sample %0d frame_end %0b", $time,
                           $signed(rsp_pcm_sample), rsp_frame_end);
               end
               mismatches++;
            end else begin
               wanted = expected_samples.pop_front();
               if (rsp_pcm_sample !== wanted.pcm_sample ||
                   rsp_frame_end !== wanted.frame_end) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: sample expected %0d got %0d, frame_end expected %0b got %0b",
                              $time, $signed(wanted.pcm_sample), $signed(rsp_pcm_sample),
                              wanted.frame_end, rsp_frame_end);
                  end
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            filter_coefficient(req_coefficient, req_stream_start);
         end

         if (csr_wr_en) begin
            boost_mode = csr_wr_data;
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_samples.size();
   end

endmodule

### tb/tb_frame_postfilter_crossfade.sv
`timescale 1ns / 100ps

module tb_frame_postfilter_crossfade;
   import fpc_pkg::*;

   localparam logic BOOST_OFF     = 1'b0;
   localparam logic BOOST_ON      = 1'b1;
   localparam int   MAX_WAIT      = 11;
   localparam int   SETTLE_CYCLES = 20;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_wr_en        = 1'b0;
   logic                csr_wr_data      = 1'b0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [IN_W-1:0]     req_coefficient  = '0;
   logic                req_stream_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [SAMPLE_W-1:0] rsp_pcm_sample;
   logic                rsp_frame_end;
   int                  mismatch_count;
   int                  pending_count;
   logic                feed_steady      = 1'b0;
   logic                drain_steady     = 1'b0;

   always #5 clock = ~clock;

   frame_postfilter_crossfade u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pcm_sample   (rsp_pcm_sample),
      .rsp_frame_end    (rsp_frame_end)
   );

   crossfade_sample_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coefficient  (req_coefficient),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pcm_sample   (rsp_pcm_sample),
      .rsp_frame_end    (rsp_frame_end),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // Mostly audio-range values, with full-scale noise and the extremes mixed in.
   function automatic logic [IN_W-1:0] draw_coefficient();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         3, 4: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
         default: return $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
      endcase
   endfunction

   // Offers one coefficient after a random gap and returns at its transfer.
   task automatic send_item(input logic [IN_W-1:0] coefficient, input logic stream_start);
      int gap;
      if ($urandom_range(0, 63) == 0) begin
         feed_steady = !feed_steady;
      end
      gap = feed_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_coefficient  <= coefficient;
      req_stream_start <= stream_start;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Starts a new stream and feeds it random content without further starts.
   task automatic send_stream(input int count);
      for (int i = 0; i < count; i++) begin
         send_item(draw_coefficient(), i == 0);
      end
   endtask

   // Waits until every expected sample has left, then lets tail items drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_boost(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // The result side stalls for a random number of cycles before each transfer.
   initial begin : sample_drain
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) begin
            drain_steady = !drain_steady;
         end
         stall = drain_steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Normal prescale: full-scale saturation both ways, rounding edges
      // around the divide by 1024, alternating bit patterns and a restart.
      write_boost(BOOST_OFF);
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(32'sd1023, 1'b0);
      send_item(-32'sd1023, 1'b0);
      send_item(32'sd1024, 1'b0);
      send_item(-32'sd1024, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'sd5_000_000, 1'b1);
      send_item(-32'sd5_000_000, 1'b0);
      settle();

      // Boost prescale: extremes and values at the edge of one output step.
      write_boost(BOOST_ON);
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'sd683, 1'b0);
      send_item(-32'sd683, 1'b0);
      send_item(32'sd1365, 1'b0);
      send_item(-32'sd1365, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      settle();

      // Short streams broken up by random restarts.
      write_boost(BOOST_OFF);
      for (int i = 0; i < 600; i++) begin
         send_item(draw_coefficient(), $urandom_range(0, 63) == 0);
      end
      settle();

      // A long stream without restarts in boost mode.
      write_boost(BOOST_ON);
      send_stream(500);
      settle();

      // A stream in normal mode, then a restart that must clear the history.
      write_boost(BOOST_OFF);
      send_stream(400);
      send_stream(80);
      settle();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guards against a block that stops transferring.
   initial begin : watchdog
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/fpc_pkg.sv
rtl/fpc_ram.sv
rtl/fpc_front.sv
rtl/fpc_queue.sv
rtl/fpc_back.sv
rtl/frame_postfilter_crossfade.sv
tb/crossfade_sample_checker.sv
tb/tb_frame_postfilter_crossfade.sv
